// File: rtl/xs128p_pkg.sv
`default_nettype none
package xs128p_pkg;

   localparam int WORD_W     = 64;
   localparam int BOUND_W    = 32;
   localparam int SPAN_W     = BOUND_W + 1;
   localparam int DIV_STEPS  = WORD_W;
   localparam int JUMP_STEPS = 2 * WORD_W;
   localparam int CNT_W      = $clog2(JUMP_STEPS);
   localparam int CSR_IDX_W  = 1;

   localparam logic [WORD_W-1:0] RESET_WORD_ZERO = 64'd12342;
   localparam logic [WORD_W-1:0] RESET_WORD_ONE  = 64'd22342;

   // Jump polynomial, bit i is tested before step i of the jump.
   localparam logic [JUMP_STEPS-1:0] JUMP_POLY = {64'h121fd2155c472f96, 64'h8a5cd789635d2dff};

   typedef enum logic [1:0] {
      KIND_RAW   = 2'd0,
      KIND_RANGE = 2'd1,
      KIND_JUMP  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SEED_ZERO = 1'd0,
      REG_SEED_ONE  = 1'd1
   } csr_reg_type;

   typedef enum logic [1:0] {
      OUT_RAW,
      OUT_EQUAL,
      OUT_RANGE
   } out_sel_type;

   typedef struct packed {
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
   } state_pair_type;

   typedef struct packed {
      logic             latch_req;
      logic             jump_clear;
      logic             advance;
      logic             draw_load;
      logic             div_step;
      logic             jump_step;
      logic             jump_commit;
      logic             out_load;
      out_sel_type      out_sel;
      logic [CNT_W-1:0] step_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic bounds_equal;
   } dp_status_type;

   // One xorshift128+ step (shifts 23, 18, 5).
   function automatic state_pair_type xs_next(input logic [WORD_W-1:0] a_in,
                                              input logic [WORD_W-1:0] b_in);
      logic [WORD_W-1:0] a;
      state_pair_type    res;
      a      = a_in ^ (a_in << 23);
      res.w0 = b_in;
      res.w1 = a ^ b_in ^ (a >> 18) ^ (b_in >> 5);
      return res;
   endfunction

endpackage
`default_nettype wire

// File: rtl/xs128p_datapath.sv
`default_nettype none
module xs128p_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  xs128p_pkg::dp_cmd_type              cmd,
   output xs128p_pkg::dp_status_type           status,
   input  logic                                csr_we,
   input  logic [xs128p_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [xs128p_pkg::WORD_W-1:0]       csr_wdata,
   input  logic signed [xs128p_pkg::BOUND_W-1:0] req_bound_low,
   input  logic signed [xs128p_pkg::BOUND_W-1:0] req_bound_high,
   output logic [xs128p_pkg::WORD_W-1:0]       rsp_random_word,
   output logic signed [xs128p_pkg::BOUND_W-1:0] rsp_ranged_value
);
   import xs128p_pkg::*;

   logic [WORD_W-1:0]         s0_ff, s0_in, s1_ff, s1_in;
   logic [WORD_W-1:0]         acc0_ff, acc0_in, acc1_ff, acc1_in;
   logic signed [BOUND_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [SPAN_W-1:0]         span_ff, span_in;
   logic [WORD_W-1:0]         quot_ff, quot_in;
   logic [SPAN_W-1:0]         rem_ff, rem_in;
   logic [WORD_W-1:0]         word_ff, word_in;
   logic signed [BOUND_W-1:0] value_ff, value_in;
   logic [WORD_W-1:0]         sum;
   logic [SPAN_W:0]           trial;
   state_pair_type            nxt;

   assign sum   = s0_ff + s1_ff;
   assign nxt   = xs_next(s0_ff, s1_ff);
   assign trial = {rem_ff, quot_ff[WORD_W-1]};

   always_comb begin
      s0_in = s0_ff;
      s1_in = s1_ff;
      if (cmd.jump_commit) begin
         s0_in = acc0_ff;
         s1_in = acc1_ff;
      end else if (cmd.advance || cmd.jump_step) begin
         s0_in = nxt.w0;
         s1_in = nxt.w1;
      end
      // seeding must only happen while idle; the datapath itself does not enforce it
      if (csr_we && csr_index == REG_SEED_ZERO) s0_in = csr_wdata;
      if (csr_we && csr_index == REG_SEED_ONE)  s1_in = csr_wdata;

      acc0_in = acc0_ff;
      acc1_in = acc1_ff;
      if (cmd.jump_clear) begin
         acc0_in = '0;
         acc1_in = '0;
      end else if (cmd.jump_step && JUMP_POLY[cmd.step_idx]) begin
         acc0_in = acc0_ff ^ s0_ff;
         acc1_in = acc1_ff ^ s1_ff;
      end
   end

   // bounds ordered on capture
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.latch_req) begin
         if (req_bound_high < req_bound_low) begin
            lo_in = req_bound_high;
            hi_in = req_bound_low;
         end else begin
            lo_in = req_bound_low;
            hi_in = req_bound_high;
         end
      end
   end

   assign status.bounds_equal = (lo_ff == hi_ff);

   // restoring remainder, one dividend bit per step
   always_comb begin
      span_in = span_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (cmd.draw_load) begin
         span_in = {hi_ff[BOUND_W-1], hi_ff} - {lo_ff[BOUND_W-1], lo_ff} + SPAN_W'(1);
         quot_in = sum;
         rem_in  = '0;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, span_ff}) begin
            rem_in = SPAN_W'(trial - {1'b0, span_ff});
         end else begin
            rem_in = trial[SPAN_W-1:0];
         end
      end
   end

   always_comb begin
      word_in  = word_ff;
      value_in = value_ff;
      if (cmd.out_load) begin
         unique case (cmd.out_sel)
            OUT_RAW: begin
               word_in  = sum;
               value_in = '0;
            end
            OUT_EQUAL: begin
               word_in  = '0;
               value_in = lo_ff;
            end
            OUT_RANGE: begin
               word_in  = '0;
               value_in = rem_ff[BOUND_W-1:0] + lo_ff;
            end
            default: begin
               word_in  = '0;
               value_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff   <= RESET_WORD_ZERO;
         s1_ff   <= RESET_WORD_ONE;
         acc0_ff <= '0;
         acc1_ff <= '0;
      end else begin
         s0_ff   <= s0_in;
         s1_ff   <= s1_in;
         acc0_ff <= acc0_in;
         acc1_ff <= acc1_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      span_ff  <= span_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      word_ff  <= word_in;
      value_ff <= value_in;
   end

   assign rsp_random_word  = word_ff;
   assign rsp_ranged_value = value_ff;

endmodule
`default_nettype wire

// File: rtl/xs128p_ctrl.sv
`default_nettype none
module xs128p_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output xs128p_pkg::dp_cmd_type        cmd,
   input  xs128p_pkg::dp_status_type     status
);
   import xs128p_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RAW,
      S_RANGE,
      S_DIV,
      S_EQUAL_OUT,
      S_RANGE_OUT,
      S_JUMP,
      S_JUMP_END
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      cmd.out_sel  = OUT_RAW;
      cmd.step_idx = count_ff;
      state_in     = state_ff;
      count_in     = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch_req = 1'b1;
               count_in      = '0;
               unique case (req_kind)
                  KIND_RAW:   state_in = S_RAW;
                  KIND_RANGE: state_in = S_RANGE;
                  KIND_JUMP: begin
                     cmd.jump_clear = 1'b1;
                     state_in       = S_JUMP;
                  end
                  default:    state_in = S_IDLE;   // unused kind dropped
               endcase
            end
         end
         S_RAW: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_RAW;
               cmd.advance  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RANGE: begin
            if (status.bounds_equal) begin
               state_in = S_EQUAL_OUT;
            end else begin
               cmd.draw_load = 1'b1;
               cmd.advance   = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_RANGE_OUT;
         end
         S_EQUAL_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_EQUAL;
               state_in     = S_IDLE;
            end
         end
         S_RANGE_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_RANGE;
               state_in     = S_IDLE;
            end
         end
         S_JUMP: begin
            cmd.jump_step = 1'b1;
            count_in      = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(JUMP_STEPS - 1)) state_in = S_JUMP_END;
         end
         S_JUMP_END: begin
            cmd.jump_commit = 1'b1;
            state_in        = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: rtl/xorshift128plus_generator.sv
`default_nettype none
// xorshift128+ generator (shifts 23, 18, 5) with a 128-bit state. Writing csr
// index 0 or 1 loads state word zero or one directly; reset state is 12342 /
// 22342. Request kinds: raw (0) returns s0+s1 and steps the state; range (1)
// returns a value in the inclusive bounds (either order), drawing one raw word
// and reducing it modulo high-low+1 unless the bounds are equal; jump (2)
// advances 2^64 steps and returns nothing; kind 3 is dropped. req_ready is
// high only while the controller is idle, one request in flight at a time.
// A range request runs the bit-serial 64-step remainder loop before its output
// state; a jump runs 128 sequenced generator steps plus a commit. The response
// register frees the front end: a new request can be taken while the previous
// response waits for rsp_ready; a finished item then holds in its output state
// until the response slot drains.
module xorshift128plus_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_we,
   input  logic [xs128p_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [xs128p_pkg::WORD_W-1:0]         csr_wdata,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_kind,
   input  logic signed [xs128p_pkg::BOUND_W-1:0] req_bound_low,
   input  logic signed [xs128p_pkg::BOUND_W-1:0] req_bound_high,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [xs128p_pkg::WORD_W-1:0]         rsp_random_word,
   output logic signed [xs128p_pkg::BOUND_W-1:0] rsp_ranged_value
);
   import xs128p_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: owns the handshake, the step counter and response valid
   xs128p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // state words, jump accumulators, remainder unit, response payload
   xs128p_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_bound_low    (req_bound_low),
      .req_bound_high   (req_bound_high),
      .rsp_random_word  (rsp_random_word),
      .rsp_ranged_value (rsp_ranged_value)
   );

`ifndef ASSERT_OFF
   // a jump never produces a response transfer right after it is taken
   a_jump_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_JUMP) |=> !$rose(rsp_valid))
      else $error("response raised after jump request");

   // an unused kind is dropped and the front end stays open
   a_unused_kind_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind != KIND_RAW && req_kind != KIND_RANGE
       && req_kind != KIND_JUMP) |=> req_ready)
      else $error("unused kind left controller busy");

   // a response carries at most one meaningful field
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_random_word == '0 || rsp_ranged_value == '0))
      else $error("both response fields nonzero");
`endif

endmodule
`default_nettype wire
